### design/rrb_pkg.sv
// rrb_pkg: sizes, byte offsets, reply byte map and shared types for the
// tcp reset reply builder. no dependencies.
`default_nettype none
package rrb_pkg;
	localparam int MAX_FRAME_BYTES = 2048;
	localparam int AW = $clog2(MAX_FRAME_BYTES);
	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int IDXW = 18;
	localparam int SUMW = 28;
	localparam int MIN_FRAME = 54;
	localparam int IP_OFS = 14;
	localparam int TOTLEN_HI = 16;
	localparam int TOTLEN_LO = 17;
	localparam int PROTO_OFS = 23;
	localparam int SRC_IP_OFS = 26;
	localparam int IP_END = 34;
	localparam logic [7:0] FLAG_KEEP = 8'h3F;
	localparam logic [7:0] RST_FLAG = 8'h04;

	typedef logic [IDXW-1:0] idx_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic [AW-1:0] addr_t;
	typedef logic [SUMW-1:0] sum_t;

	typedef enum logic [2:0] {
		OP_HELD,
		OP_ZERO,
		OP_FLAGS,
		OP_IPHI,
		OP_IPLO,
		OP_TCPHI,
		OP_TCPLO
	} rrb_op_t;

	typedef struct packed {
		idx_t    idx;
		rrb_op_t op;
		idx_t    src;
	} rrb_rd_t;

	function automatic rrb_rd_t rrb_map(input idx_t i);
		rrb_rd_t r;
		r.idx = i;
		r.op = OP_HELD;
		r.src = i;
		priority if (i < idx_t'(6)) r.src = i + idx_t'(6);
		else if (i < idx_t'(12)) r.src = i - idx_t'(6);
		else if (i == idx_t'(24)) r.op = OP_IPHI;
		else if (i == idx_t'(25)) r.op = OP_IPLO;
		else if (i >= idx_t'(26) && i < idx_t'(30)) r.src = i + idx_t'(4);
		else if (i >= idx_t'(30) && i < idx_t'(34)) r.src = i - idx_t'(4);
		else if (i == idx_t'(34) || i == idx_t'(35)) r.src = i + idx_t'(2);
		else if (i == idx_t'(36) || i == idx_t'(37)) r.src = i - idx_t'(2);
		else if (i >= idx_t'(38) && i < idx_t'(42)) r.src = i + idx_t'(4);
		else if (i >= idx_t'(42) && i < idx_t'(46)) r.op = OP_ZERO;
		else if (i == idx_t'(47)) r.op = OP_FLAGS;
		else if (i == idx_t'(48) || i == idx_t'(49)) r.op = OP_ZERO;
		else if (i == idx_t'(50)) r.op = OP_TCPHI;
		else if (i == idx_t'(51)) r.op = OP_TCPLO;
		else r.src = i;
		return r;
	endfunction

	function automatic logic [15:0] rrb_fold(input sum_t s);
		logic [16:0] a;
		logic [15:0] b;
		a = {1'b0, s[15:0]} + 17'(s[SUMW-1:16]);
		b = a[15:0] + 16'(a[16]);
		return ~b;
	endfunction
endpackage
`default_nettype wire

### design/rrb_in_if.sv
// rrb_in_if: request channel of the reset reply builder
// depends on nothing
`default_nettype none
interface rrb_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  frame_byte;
	logic        is_last_byte;
	logic [10:0] read_index;
	modport source(output valid, req_type, frame_byte, is_last_byte, read_index,
		input ready);
	modport sink(input valid, req_type, frame_byte, is_last_byte, read_index,
		output ready);
endinterface
`default_nettype wire

### design/rrb_out_if.sv
// rrb_out_if: result channel of the reset reply builder
// depends on nothing
`default_nettype none
interface rrb_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  reply_byte;
	logic [11:0] reply_length;
	logic        frame_error;
	modport source(output valid, result_kind, reply_byte, reply_length, frame_error,
		input ready);
	modport sink(input valid, result_kind, reply_byte, reply_length, frame_error,
		output ready);
endinterface
`default_nettype wire

### design/rrb_mem.sv
// rrb_mem: frame byte store, one write and one registered read port
// depends on rrb_pkg
`default_nettype none
module rrb_mem (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire rrb_pkg::addr_t waddr,
	input  wire logic [7:0]    wdata,
	input  wire rrb_pkg::addr_t raddr,
	output logic [7:0]         rdata
);
	import rrb_pkg::*;

	logic [7:0] mem_q [MAX_FRAME_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### design/rrb_fmt.sv
// rrb_fmt: turns a stored byte into the reply byte at one position
// depends on rrb_pkg
`default_nettype none
module rrb_fmt (
	input  wire rrb_pkg::rrb_rd_t rd,
	input  wire logic [7:0]       rdata,
	input  wire rrb_pkg::cnt_t    cnt,
	input  wire logic [15:0]      ip_sum,
	input  wire logic [15:0]      tcp_sum,
	output logic [7:0]            byte_out
);
	import rrb_pkg::*;

	logic [7:0] held;

	always_comb begin
		held = (rd.src < idx_t'(cnt)) ? rdata : 8'h00;
		if (rd.idx >= idx_t'(cnt)) begin
			byte_out = 8'h00;
		end else begin
			unique case (rd.op)
				OP_HELD:  byte_out = held;
				OP_ZERO:  byte_out = 8'h00;
				OP_FLAGS: byte_out = (held & ~FLAG_KEEP) | RST_FLAG;
				OP_IPHI:  byte_out = ip_sum[15:8];
				OP_IPLO:  byte_out = ip_sum[7:0];
				OP_TCPHI: byte_out = tcp_sum[15:8];
				OP_TCPLO: byte_out = tcp_sum[7:0];
				default:  byte_out = 8'h00;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/tcp_reset_reply_builder.sv
// tcp_reset_reply_builder: top level, sequencer and checksum passes
// depends on rrb_pkg, rrb_in_if, rrb_out_if, rrb_mem, rrb_fmt
`default_nettype none
// A frame byte write that is not the last byte gives no result. After the last
// byte the block makes two passes over the frame store through its single read
// port, one byte a cycle: the IP header (4 x IHL bytes), then the pseudo header
// and the TCP segment up to the end that the total length gives, at most to the
// end of the received bytes, and then offers a result of kind 0. A reply byte
// read goes through a store read, then formatting into the output register. One
// item is worked on at a time; a waiting result does not stop writes that give no
// result.
module tcp_reset_reply_builder (
	input  wire logic clk,
	input  wire logic arst_n,
	rrb_in_if.sink    req_ch,
	rrb_out_if.source rsp_ch
);
	import rrb_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_SETUP, ST_IP, ST_IPFOLD, ST_PS0, ST_PS1, ST_SEG,
		ST_TFOLD, ST_FIN
	} state_t;

	state_t      state_q;
	cnt_t        cnt_q;
	logic        ovf_q, done_q;
	logic [7:0]  b14_q, b16_q, b17_q;
	idx_t        i_q, hi_q, start_q, lim_q;
	logic [15:0] tlen_q, ip_sum_q, tcp_sum_q;
	sum_t        sum_q;
	rrb_rd_t     s1;
	logic        v_s1;
	logic        ovalid_q, kind_q, err_out_q;
	logic [7:0]  byte_q;
	logic [11:0] len_q;

	logic        wr_go, rd_go, pass_st, pass_iss, slot_free, err, we;
	cnt_t        cnt_eff;
	idx_t        iss_idx, start_c, end_c, lim_c;
	logic [5:0]  hlen;
	logic [15:0] tlen_c;
	rrb_rd_t     map_r;
	addr_t       raddr;
	logic [7:0]  rdata, fmt_byte;
	sum_t        wt;

	assign req_ch.ready = (state_q == ST_IDLE);
	assign wr_go = req_ch.valid && req_ch.ready && !req_ch.req_type;
	assign rd_go = req_ch.valid && req_ch.ready && req_ch.req_type;
	assign pass_st = (state_q == ST_IP) || (state_q == ST_PS0) || (state_q == ST_PS1)
		|| (state_q == ST_SEG);
	assign pass_iss = pass_st && (i_q < hi_q);
	assign slot_free = !ovalid_q || rsp_ch.ready;
	assign err = ovf_q || (cnt_q < cnt_t'(MIN_FRAME));

	assign cnt_eff = done_q ? '0 : cnt_q;
	assign we = wr_go && (cnt_eff < cnt_t'(MAX_FRAME_BYTES));

	assign iss_idx = rd_go ? idx_t'(req_ch.read_index) : i_q;
	assign map_r = rrb_map(iss_idx);
	assign raddr = (rd_go || pass_iss) ? map_r.src[AW-1:0] : s1.src[AW-1:0];

	assign hlen = {b14_q[3:0], 2'b00};
	assign tlen_c = {b16_q, b17_q} - 16'(hlen);
	assign start_c = idx_t'(IP_OFS) + idx_t'(hlen);
	assign end_c = start_c + idx_t'(tlen_c);
	assign lim_c = (end_c < idx_t'(cnt_q)) ? end_c : idx_t'(cnt_q);

	assign wt = s1.idx[0] ? sum_t'(fmt_byte) : (sum_t'(fmt_byte) << 8);

	rrb_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_eff[AW-1:0]),
		.wdata (req_ch.frame_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	rrb_fmt u_fmt (
		.rd       (s1),
		.rdata    (rdata),
		.cnt      (cnt_q),
		.ip_sum   (ip_sum_q),
		.tcp_sum  (tcp_sum_q),
		.byte_out (fmt_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			done_q    <= 1'b0;
			b14_q     <= '0;
			b16_q     <= '0;
			b17_q     <= '0;
			i_q       <= '0;
			hi_q      <= '0;
			start_q   <= '0;
			lim_q     <= '0;
			tlen_q    <= '0;
			ip_sum_q  <= '0;
			tcp_sum_q <= '0;
			sum_q     <= '0;
			s1        <= '0;
			v_s1      <= 1'b0;
			ovalid_q  <= 1'b0;
			kind_q    <= 1'b0;
			byte_q    <= '0;
			len_q     <= '0;
			err_out_q <= 1'b0;
		end else begin
			if (rsp_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			if (v_s1) begin
				sum_q <= sum_q + wt;
			end
			v_s1 <= pass_iss;
			if (pass_iss || rd_go) begin
				s1 <= map_r;
			end
			if (pass_iss) begin
				i_q <= i_q + idx_t'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (rd_go) begin
						state_q <= ST_RD;
					end else if (wr_go) begin
						if (done_q) begin
							done_q <= 1'b0;
							ovf_q  <= 1'b0;
							b14_q  <= '0;
							b16_q  <= '0;
							b17_q  <= '0;
						end
						if (we) begin
							cnt_q <= cnt_eff + cnt_t'(1);
							if (cnt_eff == cnt_t'(IP_OFS)) b14_q <= req_ch.frame_byte;
							if (cnt_eff == cnt_t'(TOTLEN_HI)) b16_q <= req_ch.frame_byte;
							if (cnt_eff == cnt_t'(TOTLEN_LO)) b17_q <= req_ch.frame_byte;
						end else begin
							cnt_q <= cnt_eff;
							ovf_q <= 1'b1;
						end
						if (req_ch.is_last_byte) begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_RD: begin
					if (slot_free) begin
						ovalid_q  <= 1'b1;
						kind_q    <= 1'b1;
						byte_q    <= (done_q && !err) ? fmt_byte : 8'h00;
						len_q     <= 12'(cnt_q);
						err_out_q <= err;
						state_q   <= ST_IDLE;
					end
				end
				ST_SETUP: begin
					ip_sum_q  <= '0;
					tcp_sum_q <= '0;
					sum_q     <= '0;
					tlen_q    <= tlen_c;
					start_q   <= start_c;
					lim_q     <= lim_c;
					i_q       <= idx_t'(IP_OFS);
					hi_q      <= start_c;
					state_q   <= ST_IP;
				end
				ST_IP: begin
					if (!pass_iss) state_q <= ST_IPFOLD;
				end
				ST_IPFOLD: begin
					ip_sum_q <= rrb_fold(sum_q);
					sum_q    <= sum_t'(tlen_q);
					i_q      <= idx_t'(PROTO_OFS);
					hi_q     <= idx_t'(PROTO_OFS + 1);
					state_q  <= ST_PS0;
				end
				ST_PS0: begin
					if (!pass_iss) begin
						i_q     <= idx_t'(SRC_IP_OFS);
						hi_q    <= idx_t'(IP_END);
						state_q <= ST_PS1;
					end
				end
				ST_PS1: begin
					if (!pass_iss) begin
						i_q     <= start_q;
						hi_q    <= lim_q;
						state_q <= ST_SEG;
					end
				end
				ST_SEG: begin
					if (!pass_iss) state_q <= ST_TFOLD;
				end
				ST_TFOLD: begin
					tcp_sum_q <= rrb_fold(sum_q);
					done_q    <= 1'b1;
					state_q   <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) begin
						ovalid_q  <= 1'b1;
						kind_q    <= 1'b0;
						byte_q    <= 8'h00;
						len_q     <= 12'(cnt_q);
						err_out_q <= err;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_ch.valid        = ovalid_q;
	assign rsp_ch.result_kind  = kind_q;
	assign rsp_ch.reply_byte   = byte_q;
	assign rsp_ch.reply_length = len_q;
	assign rsp_ch.frame_error  = err_out_q;

	a_ipfold_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IPFOLD |-> !v_s1) else $error("ip sum folded with byte in flight");
	a_tfold_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TFOLD |-> !v_s1) else $error("tcp sum folded with byte in flight");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(MAX_FRAME_BYTES)) else $error("byte count past store");
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> done_q) else $error("frame result without checksums");
	a_rd_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD && slot_free) |=> (ovalid_q && kind_q))
		else $error("read item gave no read result");
endmodule
`default_nettype wire

### tb/rrb_checker.sv
// rrb_checker: watches both channels of the reset reply builder, keeps its own copy of the
// frame store and checksums, and compares every result item; depends on rrb_in_if, rrb_out_if
`timescale 1ns / 100ps
module rrb_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	rrb_in_if         req_ch,
	rrb_out_if        rsp_ch,
	output int        fail_count,
	output int        outstanding
);
	localparam int STORE_BYTES = 2048;
	localparam int SHORTEST = 54;

	typedef struct {
		logic        kind;
		logic [7:0]  data;
		logic [11:0] length;
		logic        err;
	} reply_t;

	logic [7:0]  store [STORE_BYTES];
	int unsigned held_count;
	logic [15:0] ip_csum;
	logic [15:0] tcp_csum;
	logic        overflowed;
	logic        frame_ready;
	reply_t      awaited [$];

	assign outstanding = awaited.size();

	function automatic int unsigned held(int unsigned i);
		if (i >= held_count || i >= STORE_BYTES)
			return 0;
		return store[i];
	endfunction

	// phase 0: no checksums, 1: ip checksum in place, 2: both
	function automatic int unsigned reply_byte_at(int unsigned i, int phase);
		if (i >= held_count) return 0;
		if (i < 6) return held(i + 6);
		if (i < 12) return held(i - 6);
		if (i == 24) return phase >= 1 ? ip_csum[15:8] : 0;
		if (i == 25) return phase >= 1 ? ip_csum[7:0] : 0;
		if (i >= 26 && i < 30) return held(i + 4);
		if (i >= 30 && i < 34) return held(i - 4);
		if (i == 34 || i == 35) return held(i + 2);
		if (i == 36 || i == 37) return held(i - 2);
		if (i >= 38 && i < 42) return held(i + 4);
		if (i >= 42 && i < 46) return 0;
		if (i == 47) return (held(i) & 32'hC0) | 32'h04;
		if (i == 48 || i == 49) return 0;
		if (i == 50) return phase >= 2 ? tcp_csum[15:8] : 0;
		if (i == 51) return phase >= 2 ? tcp_csum[7:0] : 0;
		return held(i);
	endfunction

	function automatic logic [15:0] ones_fold(int unsigned s);
		s = (s & 32'hFFFF) + (s >> 16);
		s = (s & 32'hFFFF) + (s >> 16);
		return ~s[15:0];
	endfunction

	function automatic int unsigned word_sum(int unsigned lo, int unsigned hi, int phase);
		int unsigned s;
		s = 0;
		for (int unsigned i = lo; i < hi; i++)
			s += (i & 1) ? reply_byte_at(i, phase) : reply_byte_at(i, phase) << 8;
		return s;
	endfunction

	task automatic compute_checksums();
		int unsigned hlen, total, seg_len, seg_start, seg_end, s;
		hlen = (held(14) & 32'hF) * 4;
		total = (held(16) << 8) | held(17);
		seg_len = (total - hlen) & 32'hFFFF;
		seg_start = 14 + hlen;
		seg_end = seg_start + seg_len;
		ip_csum = 16'h0;
		tcp_csum = 16'h0;
		ip_csum = ones_fold(word_sum(14, seg_start, 0));
		s = word_sum(26, 34, 1) + reply_byte_at(23, 1) + seg_len;
		s += word_sum(seg_start, seg_end < held_count ? seg_end : held_count, 1);
		tcp_csum = ones_fold(s);
	endtask

	task automatic predict_reply(logic rd, logic [7:0] data, logic last, logic [10:0] idx);
		reply_t r;
		logic bad;
		if (!rd) begin
			if (frame_ready) begin
				held_count = 0;
				overflowed = 1'b0;
				frame_ready = 1'b0;
			end
			if (held_count < STORE_BYTES) begin
				store[held_count] = data;
				held_count++;
			end else
				overflowed = 1'b1;
			if (!last)
				return;
			compute_checksums();
			frame_ready = 1'b1;
		end
		bad = overflowed || held_count < SHORTEST;
		r.kind = rd;
		r.data = (rd && frame_ready && !bad) ? 8'(reply_byte_at(idx, 2)) : 8'h00;
		r.length = 12'(held_count);
		r.err = bad;
		awaited.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t w;
		if (!arst_n) begin
			held_count = 0;
			ip_csum = 16'h0;
			tcp_csum = 16'h0;
			overflowed = 1'b0;
			frame_ready = 1'b0;
			awaited.delete();
			fail_count = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited.size() == 0) begin
					$error("result item with nothing awaited");
					fail_count++;
				end else begin
					w = awaited.pop_front();
					if (rsp_ch.result_kind !== w.kind) begin
						$error("result_kind expected %0d got %0d", w.kind, rsp_ch.result_kind);
						fail_count++;
					end
					if (rsp_ch.reply_byte !== w.data) begin
						$error("reply_byte expected %0h got %0h", w.data, rsp_ch.reply_byte);
						fail_count++;
					end
					if (rsp_ch.reply_length !== w.length) begin
						$error("reply_length expected %0d got %0d", w.length,
							rsp_ch.reply_length);
						fail_count++;
					end
					if (rsp_ch.frame_error !== w.err) begin
						$error("frame_error expected %0d got %0d", w.err, rsp_ch.frame_error);
						fail_count++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready)
				predict_reply(req_ch.req_type, req_ch.frame_byte, req_ch.is_last_byte,
					req_ch.read_index);
		end
	end
endmodule

### tb/testbench.sv
// testbench: drives frames and reply reads into the reset reply builder and gives the verdict
// depends on rrb_in_if, rrb_out_if, rrb_checker and the block itself
`timescale 1ns / 100ps
module testbench;
	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   item_count;
	logic quiet;

	rrb_in_if  req_ch ();
	rrb_out_if rsp_ch ();

	tcp_reset_reply_builder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_ch.sink),
		.rsp_ch (rsp_ch.source)
	);

	rrb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_ch      (req_ch),
		.rsp_ch      (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// long stretch with no idling on either side
	assign quiet = item_count >= 600 && item_count < 900;

	always @(posedge clk)
		rsp_ch.ready <= quiet || $urandom_range(99) >= 9;

	task automatic send(logic rd, logic [7:0] data, logic last, logic [10:0] idx);
		while (!quiet && $urandom_range(99) < 9) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rd;
		req_ch.frame_byte <= data;
		req_ch.is_last_byte <= last;
		req_ch.read_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		item_count++;
	endtask

	task automatic send_frame(int len, int kind);
		logic [7:0] b [];
		int unsigned tot;
		b = new[len];
		foreach (b[i])
			b[i] = 8'($urandom);
		if (len > 20) begin
			b[12] = 8'h08;
			b[13] = 8'h00;
			b[14] = kind == 1 ? 8'($urandom) : 8'h45;
			tot = kind == 1 ? $urandom_range(65535) : len - 14 - (kind == 2 ? $urandom_range(6) : 0);
			b[16] = tot[15:8];
			b[17] = tot[7:0];
			b[23] = 8'h06;
		end
		foreach (b[i]) begin
			if (i > 0 && $urandom_range(99) < 2)
				send(1'b1, 8'($urandom), 1'($urandom), 11'($urandom_range(len + 2)));
			send(1'b0, b[i], i == len - 1, 11'($urandom));
		end
	endtask

	task automatic read_reply(int len);
		int pick [13] = '{0, 6, 24, 25, 26, 30, 34, 36, 38, 42, 47, 50, 51};
		int r;
		repeat ($urandom_range(3, 15)) begin
			r = $urandom_range(99);
			if (r < 40)
				send(1'b1, 8'($urandom), 1'($urandom), 11'(pick[$urandom_range(12)]));
			else if (r < 70)
				send(1'b1, 8'($urandom), 1'($urandom), 11'($urandom_range(len + 2)));
			else
				send(1'b1, 8'($urandom), 1'($urandom), 11'($urandom_range(2047)));
		end
	endtask

	initial begin
		int len, r;
		logic big_done;
		big_done = 1'b0;
		item_count = 0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= 1'b0;
		req_ch.frame_byte <= 8'h00;
		req_ch.is_last_byte <= 1'b0;
		req_ch.read_index <= 11'h0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads with no frame, then a short frame with extreme bytes
		send(1'b1, 8'hFF, 1'b1, 11'd0);
		send(1'b1, 8'h00, 1'b0, 11'd2047);
		send(1'b0, 8'h00, 1'b0, 11'd2047);
		send(1'b0, 8'hFF, 1'b0, 11'd0);
		send(1'b0, 8'h80, 1'b1, 11'd0);
		send(1'b1, 8'h00, 1'b0, 11'd1);
		send(1'b1, 8'h00, 1'b0, 11'd2);
		send(1'b1, 8'h00, 1'b0, 11'd3);

		while (item_count < 1750) begin
			r = $urandom_range(99);
			if (!big_done && item_count > 1000) begin
				big_done = 1'b1;
				len = 2049 + $urandom_range(2);
				send_frame(len, 0);
			end else if (r < 70) begin
				len = $urandom_range(54, 110);
				send_frame(len, r < 60 ? 0 : 2);
			end else if (r < 82) begin
				len = $urandom_range(54, 130);
				send_frame(len, 1);
			end else begin
				len = $urandom_range(1, 53);
				send_frame(len, 0);
			end
			read_reply(len);
		end
		req_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("PASS tcp_reset_reply_builder");
		else
			$display("FAIL tcp_reset_reply_builder");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL tcp_reset_reply_builder");
		$finish;
	end
endmodule
